// ===== rtl/iqrtm_pkg.sv =====
// ----------------------------------------------------------------------------
// iqrtm_pkg: shared types and constants
// Field widths, status codes, result kinds and sequencer states of the
// interquartile trimmed-mean outlier flagger.
// ----------------------------------------------------------------------------
package iqrtm_pkg;

	localparam int COV_W  = 24;
	localparam int IDX_W  = 6;
	localparam int MEAN_W = 16;
	localparam int PROD_W = 28;
	localparam int MIN_VALUES = 4;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FEW   = 2'd1,
		ST_EMPTY = 2'd2,
		ST_OVF   = 2'd3
	} status_t;

	typedef enum logic {
		KIND_OUTLIER = 1'b0,
		KIND_SUMMARY = 1'b1
	} kind_t;

	typedef enum logic [3:0] {
		S_LOAD,
		S_CLOSE,
		S_CAND_A,
		S_CAND_D,
		S_INNER_A,
		S_INNER_D,
		S_EVAL,
		S_SUM_A,
		S_SUM_D,
		S_CHECK,
		S_DIV_WAIT,
		S_THRESH,
		S_SCAN_A,
		S_SCAN_D,
		S_SUMMARY
	} state_t;

endpackage

// ===== rtl/iqr_trimmed_mean_outlier_flag_top.sv =====
// ----------------------------------------------------------------------------
// iqr_trimmed_mean_outlier_flag_top: interquartile trimmed mean and outliers
// Loads a set of Q16.8 coverage values, finds the rank-Q1 and rank-Q3
// values, averages the values strictly between them and reports the values
// far below or above that mean, then one summary transfer.
// ----------------------------------------------------------------------------
// Values are taken one per cycle until the transfer with tlast. The set is
// then processed while the input is held off: ranking compares each stored
// value against all others through the single read port of the value store,
// the band sum reads each value once, the mean division gives one quotient
// bit per cycle (16 plus log2(MAX_ITEMS + 1) rounded up bits, 22 for 32
// items), and the outlier scan reads each value once, holding an outlier
// while the output is stalled. Sets with too few values or with dropped
// values give only the summary transfer, by way of S_CLOSE and S_SUMMARY.
// A set with an empty middle band gives only the summary transfer, right
// after the ranking and the band sum. Input is accepted again once the
// summary has been placed in the output register.
// ----------------------------------------------------------------------------
module iqr_trimmed_mean_outlier_flag_top #(
	parameter int MAX_ITEMS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [23:0] coverage
	input  logic        s_tlast,   // end_of_set
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [5:0] chromosome_index, [21:6] mean_coverage,
	                               // [23:22] status
	output logic        m_tlast,   // last_result
	output logic        m_tuser    // kind
);

	import iqrtm_pkg::*;

	localparam int AW  = $clog2(MAX_ITEMS);
	localparam int CW  = $clog2(MAX_ITEMS + 1);
	localparam int SW  = COV_W + CW;
	localparam int NW  = SW - 8;

	state_t state_q, state_d;

	logic [CW-1:0]     count_q;
	logic              ovf_q;
	logic [AW-1:0]     i_q;
	logic [AW-1:0]     j_q;
	logic [AW-1:0]     last_idx;
	logic [CW-1:0]     q1_q;
	logic [CW-1:0]     q3_q;
	logic [CW-1:0]     lt_q;
	logic [CW-1:0]     le_q;
	logic [COV_W-1:0]  cand_q;
	logic [COV_W-1:0]  lo_q;
	logic [COV_W-1:0]  hi_q;
	logic [SW-1:0]     sum_q;
	logic [CW-1:0]     mcnt_q;
	logic [MEAN_W-1:0] mean_q;
	logic [PROD_W-1:0] thr_lo_q;
	logic [PROD_W-1:0] thr_hi_q;
	status_t           status_q;

	logic              out_valid_q;
	logic [23:0]       out_data_q;
	logic              out_last_q;
	logic              out_kind_q;

	logic              s_fire;
	logic              store_we;
	logic [AW-1:0]     raddr;
	logic [COV_W-1:0]  rdata;
	logic              push_ok;
	logic              push;
	logic              push_summary;
	logic              div_start;
	logic              div_done;
	logic [NW-1:0]     div_quo;
	logic [SW-1:0]     num_full;
	logic [CW-1:0]     q1_w;
	logic [CW-1:0]     q2_w;
	logic [CW:0]       q3_w;
	logic [PROD_W-1:0] v10;
	logic              outlier;
	logic              last_step;

	assign s_tready = (state_q == S_LOAD);
	assign s_fire   = s_tvalid && s_tready;
	assign store_we = s_fire && (count_q < CW'(MAX_ITEMS));
	assign last_idx = AW'(count_q - 1'b1);
	assign push_ok  = !out_valid_q || m_tready;

	assign raddr = (state_q == S_INNER_A || state_q == S_INNER_D) ? j_q : i_q;

	iqrtm_ram #(
		.WIDTH(COV_W),
		.DEPTH(MAX_ITEMS)
	) u_store (
		.clk  (clk),
		.we   (store_we),
		.waddr(count_q[AW-1:0]),
		.wdata(s_tdata[COV_W-1:0]),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign num_full = sum_q + SW'({mcnt_q, 7'b0});

	iqrtm_div #(
		.NW(NW),
		.DW(CW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (num_full[SW-1:8]),
		.den   (mcnt_q),
		.done  (div_done),
		.quo   (div_quo)
	);

	assign q1_w = count_q >> 2;
	assign q2_w = count_q >> 1;
	assign q3_w = {1'b0, q2_w} + {1'b0, (q1_w == '0) ? CW'(1) : q1_w};

	assign v10     = PROD_W'({rdata, 3'b0}) + PROD_W'({rdata, 1'b0});
	assign outlier = (v10 < thr_lo_q) || (v10 > thr_hi_q);
	assign last_step = (i_q == last_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		push         = 1'b0;
		push_summary = 1'b0;
		div_start    = 1'b0;
		case (state_q)
			S_LOAD: begin
				if (s_fire && s_tlast) begin
					state_d = S_CLOSE;
				end
			end
			S_CLOSE: begin
				if (ovf_q || count_q < CW'(MIN_VALUES)) begin
					state_d = S_SUMMARY;
				end else begin
					state_d = S_CAND_A;
				end
			end
			S_CAND_A:  state_d = S_CAND_D;
			S_CAND_D:  state_d = S_INNER_A;
			S_INNER_A: state_d = S_INNER_D;
			S_INNER_D: begin
				state_d = (j_q == last_idx) ? S_EVAL : S_INNER_A;
			end
			S_EVAL: begin
				state_d = last_step ? S_SUM_A : S_CAND_A;
			end
			S_SUM_A: state_d = S_SUM_D;
			S_SUM_D: begin
				state_d = last_step ? S_CHECK : S_SUM_A;
			end
			S_CHECK: begin
				if (mcnt_q == '0) begin
					state_d = S_SUMMARY;
				end else begin
					div_start = 1'b1;
					state_d   = S_DIV_WAIT;
				end
			end
			S_DIV_WAIT: begin
				if (div_done) begin
					state_d = S_THRESH;
				end
			end
			S_THRESH: state_d = S_SCAN_A;
			S_SCAN_A: state_d = S_SCAN_D;
			S_SCAN_D: begin
				if (!outlier || push_ok) begin
					push    = outlier;
					state_d = last_step ? S_SUMMARY : S_SCAN_A;
				end
			end
			S_SUMMARY: begin
				if (push_ok) begin
					push         = 1'b1;
					push_summary = 1'b1;
					state_d      = S_LOAD;
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (store_we) begin
				count_q <= count_q + 1'b1;
			end else if (s_fire) begin
				ovf_q <= 1'b1;
			end
			if (push_summary) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_CLOSE: begin
				i_q  <= '0;
				q1_q <= q1_w;
				q3_q <= (q3_w >= {1'b0, count_q}) ? CW'(count_q - 1'b1) : q3_w[CW-1:0];
				if (ovf_q) begin
					status_q <= ST_OVF;
				end else begin
					status_q <= ST_FEW;
				end
			end
			S_CAND_D: begin
				cand_q <= rdata;
				j_q    <= '0;
				lt_q   <= '0;
				le_q   <= '0;
			end
			S_INNER_D: begin
				if (rdata < cand_q) begin
					lt_q <= lt_q + 1'b1;
				end
				if (rdata <= cand_q) begin
					le_q <= le_q + 1'b1;
				end
				j_q <= j_q + 1'b1;
			end
			S_EVAL: begin
				if (lt_q <= q1_q && q1_q < le_q) begin
					lo_q <= cand_q;
				end
				if (lt_q <= q3_q && q3_q < le_q) begin
					hi_q <= cand_q;
				end
				if (last_step) begin
					i_q    <= '0;
					sum_q  <= '0;
					mcnt_q <= '0;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
			S_SUM_D: begin
				if (rdata > lo_q && rdata < hi_q) begin
					sum_q  <= sum_q + SW'(rdata);
					mcnt_q <= mcnt_q + 1'b1;
				end
				i_q <= i_q + 1'b1;
			end
			S_CHECK: begin
				status_q <= ST_EMPTY;
			end
			S_DIV_WAIT: begin
				if (div_done) begin
					mean_q <= (|div_quo[NW-1:MEAN_W]) ? '1 : div_quo[MEAN_W-1:0];
				end
			end
			S_THRESH: begin
				thr_lo_q <= PROD_W'({mean_q, 10'b0}) + PROD_W'({mean_q, 9'b0});
				thr_hi_q <= PROD_W'({mean_q, 12'b0}) - PROD_W'({mean_q, 9'b0});
				status_q <= ST_OK;
				i_q      <= '0;
			end
			S_SCAN_D: begin
				if (!outlier || push_ok) begin
					i_q <= i_q + 1'b1;
				end
			end
			default: begin
			end
		endcase

		if (push) begin
			if (push_summary) begin
				out_kind_q <= KIND_SUMMARY;
				out_last_q <= 1'b1;
				out_data_q <= {status_q, (status_q == ST_OK) ? mean_q : MEAN_W'(0),
					IDX_W'(0)};
			end else begin
				out_kind_q <= KIND_OUTLIER;
				out_last_q <= 1'b0;
				out_data_q <= {ST_OK, mean_q, IDX_W'(i_q)};
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_kind_q;

endmodule

// ===== rtl/iqrtm_ram.sv =====
// ----------------------------------------------------------------------------
// iqrtm_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module iqrtm_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/iqrtm_div.sv =====
// ----------------------------------------------------------------------------
// iqrtm_div: iterative restoring divider
// Produces one quotient bit per cycle; done pulses when the quotient is final.
// ----------------------------------------------------------------------------
module iqrtm_div #(
	parameter int NW = 22,
	parameter int DW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);

	localparam int CW = $clog2(NW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [DW:0]   trial;
	logic          fits;

	assign trial = {rem_q, quo_q[NW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], fits};
			rem_q <= fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== dv/iqr_trimmed_mean_outlier_flag_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// iqr_trimmed_mean_outlier_flag_top_tb: self-checking bench for the flagger
// Streams sets of Q16.8 coverage values into the block. A predictor ranks
// each set, forms the interquartile trimmed mean and lists the expected
// outlier and summary transfers. Every output transfer is checked against
// them field by field, under random idling on both sides of the block.
// ----------------------------------------------------------------------------
module iqr_trimmed_mean_outlier_flag_top_tb;

	import iqrtm_pkg::*;

	localparam int MAX_VALUES = 32;
	localparam int LONG_HOLD  = 1000;

	typedef enum int {
		SPREAD_CLUSTER,
		SPREAD_UNIFORM,
		SPREAD_TIES
	} spread_t;

	typedef struct {
		kind_t              kind;
		logic [IDX_W-1:0]   chrom_idx;
		logic [MEAN_W-1:0]  mean;
		status_t            status;
		logic               last;
	} report_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [COV_W-1:0]  s_tdata = '0;
	logic              s_tlast = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [23:0]       m_tdata;
	logic              m_tlast;
	logic              m_tuser;

	report_t           pending_reports[$];
	report_t           next_report;
	logic [COV_W-1:0]  loaded_cov[MAX_VALUES];
	int unsigned       loaded_n = 0;
	bit                lost_value = 1'b0;

	bit                idle_en = 1'b1;
	bit                rx_hold = 1'b0;
	int unsigned       stall_left = 0;
	int unsigned       mismatch_count = 0;
	int unsigned       items_sent = 0;
	int unsigned       sets_sent = 0;
	int unsigned       outliers_seen = 0;
	int unsigned       status_seen[4] = '{0, 0, 0, 0};

	iqr_trimmed_mean_outlier_flag_top #(
		.MAX_ITEMS(MAX_VALUES)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [23:0] coverage
		.s_tlast  (s_tlast),   // end_of_set
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [5:0] chromosome_index, [21:6] mean_coverage, [23:22] status
		.m_tlast  (m_tlast),   // last_result
		.m_tuser  (m_tuser)    // kind
	);

	always #4 clk = ~clk;

	function automatic void expect_report(report_t rep);
		pending_reports = {pending_reports, rep};
	endfunction

	function automatic void close_coverage_set();
		logic [COV_W-1:0]  ranked[MAX_VALUES];
		logic [COV_W-1:0]  key;
		logic [COV_W-1:0]  lo_val;
		logic [COV_W-1:0]  hi_val;
		int unsigned       q1;
		int unsigned       q2;
		int unsigned       q3;
		int unsigned       cnt;
		int                j;
		longint unsigned   band_sum;
		longint unsigned   mean_full;
		longint unsigned   v10;
		report_t           rep;
		report_t           flag;
		rep = '{kind: KIND_SUMMARY, chrom_idx: '0, mean: '0, status: ST_OK, last: 1'b1};
		if (lost_value) begin
			rep.status = ST_OVF;
			expect_report(rep);
			return;
		end
		if (loaded_n < MIN_VALUES) begin
			rep.status = ST_FEW;
			expect_report(rep);
			return;
		end
		for (int i = 0; i < loaded_n; i++) begin
			key = loaded_cov[i];
			j = i;
			while (j > 0 && ranked[j - 1] > key) begin
				ranked[j] = ranked[j - 1];
				j--;
			end
			ranked[j] = key;
		end
		q1 = loaded_n / 4;
		q2 = loaded_n / 2;
		q3 = q2 + ((q1 == 0) ? 1 : q1);
		if (q3 >= loaded_n)
			q3 = loaded_n - 1;
		lo_val = ranked[q1];
		hi_val = ranked[q3];
		band_sum = 0;
		cnt = 0;
		for (int i = 0; i < loaded_n; i++) begin
			if (ranked[i] > lo_val && ranked[i] < hi_val) begin
				band_sum += ranked[i];
				cnt++;
			end
		end
		if (cnt == 0) begin
			rep.status = ST_EMPTY;
			expect_report(rep);
			return;
		end
		mean_full = (band_sum + 128 * longint'(cnt)) / (256 * longint'(cnt));
		if (mean_full > 65535)
			mean_full = 65535;
		rep.mean = mean_full[MEAN_W-1:0];
		for (int i = 0; i < loaded_n; i++) begin
			v10 = longint'(loaded_cov[i]) * 10;
			if (v10 < mean_full * 1536 || v10 > mean_full * 3584) begin
				flag = '{kind: KIND_OUTLIER, chrom_idx: i[IDX_W-1:0],
					mean: rep.mean, status: ST_OK, last: 1'b0};
				expect_report(flag);
			end
		end
		expect_report(rep);
	endfunction

	function automatic void load_coverage(logic [COV_W-1:0] cov, logic end_of_set);
		if (loaded_n < MAX_VALUES) begin
			loaded_cov[loaded_n] = cov;
			loaded_n++;
		end else begin
			lost_value = 1'b1;
		end
		if (end_of_set) begin
			close_coverage_set();
			loaded_n = 0;
			lost_value = 1'b0;
		end
	endfunction

	function automatic logic [COV_W-1:0] pick_coverage(spread_t spread, int unsigned base);
		int unsigned width;
		int unsigned v;
		case (spread)
			SPREAD_CLUSTER: begin
				width = base / 4 + 1;
				v = base - width + $urandom_range(0, 2 * width);
				if ($urandom_range(0, 7) == 0)
					v = $urandom_range(0, 1) ? base / 3 : base * 2;
			end
			SPREAD_UNIFORM: begin
				v = $urandom_range(0, 24'hFFFFFF);
			end
			default: begin
				v = base + $urandom_range(0, 2);
			end
		endcase
		if (v > 24'hFFFFFF)
			v = 24'hFFFFFF;
		return v[COV_W-1:0];
	endfunction

	task automatic send_coverage(input logic [COV_W-1:0] cov, input logic end_of_set);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= cov;
		s_tlast  <= end_of_set;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
		if (end_of_set)
			sets_sent++;
		load_coverage(cov, end_of_set);
	endtask

	task automatic send_list(input logic [COV_W-1:0] values[$]);
		foreach (values[i])
			send_coverage(values[i], i == values.size() - 1);
	endtask

	task automatic send_random_set(input int unsigned n, input spread_t spread);
		int unsigned base;
		base = $urandom_range(16, 24'h7FFFFF);
		for (int i = 0; i < n; i++)
			send_coverage(pick_coverage(spread, base), i == n - 1);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
	endtask

	task automatic test_short_sets();
		send_list('{24'hFFFFFF});
		send_list('{24'h000000, 24'hFFFFFF, 24'h800000});
	endtask

	task automatic test_empty_band();
		send_list('{24'h006400, 24'h006400, 24'h006400, 24'h006400});
	endtask

	task automatic test_saturated_mean();
		send_list('{24'hFFFFFE, 24'h000000, 24'hFFFFFF, 24'hFFFFFC, 24'hFFFFFD,
			24'hFFFFFF});
	endtask

	task automatic test_outlier_flags();
		send_list('{24'h002800, 24'h006400, 24'h006200, 24'h006600, 24'h006500,
			24'h006300, 24'h00C800, 24'h006400});
	endtask

	task automatic test_full_store();
		send_random_set(MAX_VALUES, SPREAD_UNIFORM);
		send_random_set(MAX_VALUES + 1, SPREAD_CLUSTER);
	endtask

	task automatic test_random_sets();
		int unsigned start_count;
		int unsigned n;
		int unsigned pick;
		spread_t     spread;
		start_count = items_sent;
		while (items_sent - start_count < 25) begin
			pick = $urandom_range(0, 9);
			if (pick == 0)
				n = $urandom_range(1, 3);
			else if (pick == 1)
				n = $urandom_range(13, MAX_VALUES);
			else
				n = $urandom_range(4, 12);
			pick = $urandom_range(0, 9);
			if (pick < 6)
				spread = SPREAD_CLUSTER;
			else if (pick < 8)
				spread = SPREAD_UNIFORM;
			else
				spread = SPREAD_TIES;
			if (pick == 9)
				idle_en = 1'b0;
			send_random_set(n, spread);
			idle_en = 1'b1;
		end
	endtask

	task automatic test_output_hold();
		fork
			begin
				rx_hold = 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				rx_hold = 1'b0;
			end
			begin
				send_random_set(5, SPREAD_CLUSTER);
				send_random_set(5, SPREAD_CLUSTER);
				send_random_set(5, SPREAD_CLUSTER);
			end
		join
	endtask

	task automatic test_drain_pause();
		send_random_set(6, SPREAD_CLUSTER);
		wait_drained();
		send_random_set(5, SPREAD_CLUSTER);
	endtask

	task automatic test_back_to_back();
		idle_en = 1'b0;
		for (int i = 0; i < 3; i++)
			send_random_set($urandom_range(4, 8), SPREAD_CLUSTER);
	endtask

	always @(posedge clk) begin
		if (!arst_n || rx_hold) begin
			m_tready <= 1'b0;
		end else if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_en && $urandom_range(0, 7) == 0) begin
			m_tready <= 1'b0;
			stall_left <= $urandom_range(0, 13);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			status_seen[m_tdata[23:22]]++;
			if (m_tuser == KIND_OUTLIER)
				outliers_seen++;
			if (pending_reports.size() == 0) begin
				$error("transfer with nothing expected: tdata=%h tlast=%b tuser=%b",
					m_tdata, m_tlast, m_tuser);
				mismatch_count++;
			end else begin
				next_report = pending_reports.pop_front();
				if (m_tuser !== next_report.kind) begin
					$error("kind: expected %0d, actual %0d", next_report.kind, m_tuser);
					mismatch_count++;
				end
				if (m_tdata[5:0] !== next_report.chrom_idx) begin
					$error("chromosome_index: expected %0d, actual %0d",
						next_report.chrom_idx, m_tdata[5:0]);
					mismatch_count++;
				end
				if (m_tdata[21:6] !== next_report.mean) begin
					$error("mean_coverage: expected %0d, actual %0d",
						next_report.mean, m_tdata[21:6]);
					mismatch_count++;
				end
				if (m_tdata[23:22] !== next_report.status) begin
					$error("status: expected %0d, actual %0d",
						next_report.status, m_tdata[23:22]);
					mismatch_count++;
				end
				if (m_tlast !== next_report.last) begin
					$error("last_result: expected %0d, actual %0d",
						next_report.last, m_tlast);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d transfers still expected.", pending_reports.size());
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		test_short_sets();
		test_empty_band();
		test_saturated_mean();
		test_outlier_flags();
		test_full_store();
		test_random_sets();
		test_output_hold();
		test_drain_pause();
		test_back_to_back();
		wait_drained();
		repeat (50) @(posedge clk);
		$display("Sent %0d coverage values in %0d sets; received %0d outlier reports.",
			items_sent, sets_sent, outliers_seen);
		$display("Transfers by status: ok %0d, too few %0d, empty band %0d, overflow %0d.",
			status_seen[ST_OK], status_seen[ST_FEW], status_seen[ST_EMPTY],
			status_seen[ST_OVF]);
		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/iqrtm_pkg.sv
rtl/iqrtm_ram.sv
rtl/iqrtm_div.sv
rtl/iqr_trimmed_mean_outlier_flag_top.sv
dv/iqr_trimmed_mean_outlier_flag_top_tb.sv
